// ===== rtl/core/kct_pkg.sv =====
// Package: request/result types and status codes for the keyed counter table.
package kct_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TRY    = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_NOT_ENOUGH = 3'd3;
  localparam logic [2:0] ST_BAD_KEY    = 3'd4;

  localparam int KEY_W = 31;
  localparam int CNT_W = 32;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] item_key;
    logic [KEY_W-1:0] amount;
  } kct_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] count_now;
    logic [5:0]       slot_used;
    logic             enough;
    logic             slot_freed;
  } kct_rsp_t;

  // Lookup result flowing along the slot chain.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] count;
  } kct_hit_t;

  // Write command broadcast to the slot chain.
  typedef struct packed {
    logic             we;
    logic             clr;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } kct_wr_t;

endpackage

// ===== rtl/core/kct_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kct_cell.sv =====
// One slot cell: holds key and count, compares the key and forwards the hit.
module kct_cell import kct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] look_key,
  input  kct_hit_t         hit_in,
  output kct_hit_t         hit_out,
  input  logic             sel,
  input  kct_wr_t          wr
);

  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] cnt_r;
  logic             match;

  // key update; zero key marks an empty slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (sel && wr.we) begin
      key_r <= wr.clr ? '0 : wr.key;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.we) begin
      cnt_r <= wr.clr ? '0 : wr.count;
    end
  end

  // lowest matching slot wins: earlier cells take priority
  assign match = (key_r != '0) && (key_r == look_key);
  always_comb begin
    hit_out = hit_in;
    if (!hit_in.hit && match) begin
      hit_out.hit   = 1'b1;
      hit_out.count = cnt_r;
    end
  end

endmodule

// ===== rtl/core/kct_chain.sv =====
// Row of slot cells plus one-hot match index encode.
module kct_chain import kct_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [KEY_W-1:0]         look_key,
  output logic                     hit,
  output logic [$clog2(SLOTS)-1:0] hit_idx,
  output logic [CNT_W-1:0]         hit_cnt,
  input  logic [$clog2(SLOTS)-1:0] wr_idx,
  input  kct_wr_t                  wr
);

  localparam int IW = $clog2(SLOTS);

  kct_hit_t h [SLOTS+1];
  logic [SLOTS-1:0] first;

  assign h[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    kct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .look_key (look_key),
      .hit_in   (h[i]),
      .hit_out  (h[i+1]),
      .sel      (wr_idx == IW'(i)),
      .wr       (wr)
    );
    assign first[i] = h[i+1].hit && !h[i].hit;
  end

  // index of the first hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit     = h[SLOTS].hit;
  assign hit_cnt = h[SLOTS].count;

endmodule

// ===== rtl/core/keyed_counter_table_with_free_slots_unit.sv =====
// Top level: keyed counter table with slot chain and free-slot FIFO.
// Timing: an accepted request is registered; lookup and update happen in the
// single execute state, and the result is registered at its end.
// Throughput: each request is accepted, then executed, before the next accept;
// a held result blocks the next accept until out_ready.
// Reset: after rst_n all slots are empty; the free list fills slots 0..N-1 in
// order by an init sweep, during which no request is taken.
module keyed_counter_table_with_free_slots_unit import kct_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kct_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kct_rsp_t out_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int TW = $clog2(SLOT_COUNT + 1);
  localparam logic [TW-1:0] FULL_TOTAL = TW'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] init_r;
  logic [IW-1:0] head_r, tail_r;
  logic [TW-1:0] total_r;
  kct_req_t      req_r;
  kct_rsp_t      rsp_r;
  logic          ovalid_r;

  logic          hit;
  logic [IW-1:0] hit_idx, wr_idx;
  logic [CNT_W-1:0] hit_cnt;
  kct_wr_t       wr;

  logic          fw_we;
  logic [IW-1:0] fw_addr, fw_data, free_slot;

  kct_rsp_t      rsp;
  logic          pop, push;

  kct_chain #(.SLOTS(SLOT_COUNT)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .look_key (req_r.item_key),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .hit_cnt  (hit_cnt),
    .wr_idx   (wr_idx),
    .wr       (wr)
  );

  // free list; head read runs ahead so the head slot is ready at execute
  kct_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_free (
    .clk   (clk),
    .we    (fw_we),
    .waddr (fw_addr),
    .wdata (fw_data),
    .raddr (head_r),
    .rdata (free_slot)
  );

  assign in_ready = (state_r == S_IDLE) && (!ovalid_r || out_ready);

  // execute: decide operation from lookup
  always_comb begin
    logic [CNT_W-1:0] base, room, amt, mv, nc;
    logic             en;
    base = '0; room = '0; mv = '0; nc = '0;
    amt  = CNT_W'(req_r.amount);
    en   = hit && (hit_cnt >= amt);
    rsp  = '0;
    wr   = '0;
    wr.key = req_r.item_key;
    wr_idx = hit_idx;
    pop  = 1'b0;
    push = 1'b0;
    if (req_r.item_key == '0) begin
      rsp.status = ST_BAD_KEY;
    end else begin
      rsp.enough = en;
      if (req_r.kind == KIND_ADD) begin
        if (!hit && total_r == '0) begin
          rsp.status = ST_FULL;
        end else begin
          if (!hit) begin
            wr_idx = free_slot;
            pop    = 1'b1;
          end
          base = hit ? hit_cnt : '0;
          room = CNT_MAX - base;
          mv   = (amt < room) ? amt : room;
          nc   = base + mv;
          wr.we    = 1'b1;
          wr.count = nc;
          rsp.moved     = mv;
          rsp.count_now = nc;
          rsp.slot_used = 6'(wr_idx);
        end
      end else if (!hit) begin
        rsp.status = ST_NOT_FOUND;
      end else if (req_r.kind == KIND_QUERY) begin
        rsp.count_now = hit_cnt;
        rsp.slot_used = 6'(hit_idx);
      end else if (req_r.kind == KIND_TRY && !en) begin
        rsp.status    = ST_NOT_ENOUGH;
        rsp.count_now = hit_cnt;
        rsp.slot_used = 6'(hit_idx);
      end else begin
        mv = (hit_cnt < amt) ? hit_cnt : amt;
        nc = hit_cnt - mv;
        wr.we    = 1'b1;
        wr.count = nc;
        wr.clr   = (nc == '0);
        push     = (nc == '0);
        rsp.moved      = mv;
        rsp.count_now  = nc;
        rsp.slot_used  = 6'(hit_idx);
        rsp.slot_freed = (nc == '0);
      end
    end
    if (state_r != S_EXEC) begin
      wr.we = 1'b0;
      pop   = 1'b0;
      push  = 1'b0;
    end
  end

  // free-list writes: init sweep, then released slots at the tail
  always_comb begin
    fw_we   = 1'b0;
    fw_addr = init_r;
    fw_data = init_r;
    if (state_r == S_INIT) begin
      fw_we = 1'b1;
    end else if (push && total_r < FULL_TOTAL) begin
      fw_we   = 1'b1;
      fw_addr = tail_r;
      fw_data = hit_idx;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (init_r == IW'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid && in_ready) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      init_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      total_r  <= FULL_TOTAL;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        init_r <= init_r + 1'b1;
      end
      if (pop) begin
        head_r  <= (head_r == IW'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
        total_r <= total_r - 1'b1;
      end else if (push && total_r < FULL_TOTAL) begin
        tail_r  <= (tail_r == IW'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
        total_r <= total_r + 1'b1;
      end
      if (state_r == S_EXEC) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (state_r == S_EXEC) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = rsp_r;

  // free count never exceeds the table size
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= FULL_TOTAL) else $error("free total out of range");

  // a pop never happens with an empty free list
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> total_r != '0) else $error("pop from empty free list");

  // no request taken while sweeping the free list
  a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> !in_ready) else $error("accept during init");

  // execute always produces a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_valid) else $error("result missing");

endmodule
